/* rtl/wwva_pkg.sv */
// ----------------------------------------------------------------------------
// wwva_pkg: shared types and constants of the wide-word VM ALU
// Word geometry, opcode codes, datapath select codes, FSM states, and the
// command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package wwva_pkg;

  localparam int WORD_LIMBS = 4;
  localparam int LIMB_W     = 64;
  localparam int WORD_W     = LIMB_W * WORD_LIMBS;
  localparam int BYTES      = WORD_W / 8;
  localparam int SHAMT_W    = $clog2(WORD_W);
  localparam int BYTE_W     = $clog2(BYTES);
  localparam int POS_W      = (WORD_LIMBS > 1) ? $clog2(WORD_LIMBS) : 1;
  localparam int CNT_W      = $clog2(2 * WORD_W);
  localparam int OP_W       = 5;
  localparam int SLOT_W     = 2;
  localparam int IDX_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 5'd0,
    OP_MUL     = 5'd1,
    OP_SUB     = 5'd2,
    OP_DIV     = 5'd3,
    OP_SDIV    = 5'd4,
    OP_MOD     = 5'd5,
    OP_SMOD    = 5'd6,
    OP_ADDMOD  = 5'd7,
    OP_MULMOD  = 5'd8,
    OP_EXP     = 5'd9,
    OP_SIGNEXT = 5'd10,
    OP_LT      = 5'd11,
    OP_GT      = 5'd12,
    OP_SLT     = 5'd13,
    OP_EQ      = 5'd14,
    OP_ISZERO  = 5'd15,
    OP_AND     = 5'd16,
    OP_OR      = 5'd17,
    OP_XOR     = 5'd18,
    OP_NOT     = 5'd19,
    OP_BYTE    = 5'd20,
    OP_SHL     = 5'd21,
    OP_SHR     = 5'd22
  } opcode_e;

  typedef enum logic [SLOT_W-1:0] {
    SLOT_X = 2'd0,
    SLOT_Y = 2'd1,
    SLOT_M = 2'd2
  } slot_e;

  typedef enum logic [1:0] {
    MUL_XY,
    MUL_RB,
    MUL_BB
  } mul_src_e;

  typedef enum logic [1:0] {
    NUM_X,
    NUM_ABS,
    NUM_SUM,
    NUM_PROD
  } num_src_e;

  typedef enum logic [2:0] {
    RES_ALU,
    RES_ZERO,
    RES_ONE,
    RES_MUL,
    RES_QUO,
    RES_REM,
    RES_SQUO,
    RES_SREM
  } res_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MUL,
    ST_MUL_DONE,
    ST_DIV,
    ST_DIV_DONE,
    ST_EXP_CHK,
    ST_EXP_RM,
    ST_EXP_RM_DONE,
    ST_EXP_SQ,
    ST_EXP_SQ_DONE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic             store;
    logic [OP_W-1:0]  op;
    logic             mul_load;
    mul_src_e         mul_src;
    logic             mul_step;
    logic             div_load;
    num_src_e         num_src;
    logic             div_step;
    logic             res_load;
    res_sel_e         res_sel;
    logic             base_from_x;
    logic             base_from_mul;
    logic             ebits_load;
    logic             ebits_shift;
    logic [POS_W-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic y_zero;
    logic m_zero;
    logic ebits_zero;
    logic ebits_lsb;
  } sts_t;

endpackage

/* rtl/wwva_dp.sv */
// ----------------------------------------------------------------------------
// wwva_dp: datapath of the wide-word VM ALU
// Operand words, combinational logic/compare/shift unit, bit-serial
// shift-add multiplier, restoring divider, exponent and result registers.
// ----------------------------------------------------------------------------
module wwva_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wwva_pkg::cmd_t              cmd_i,
  input  logic [wwva_pkg::SLOT_W-1:0] operand_slot_i,
  input  logic [wwva_pkg::IDX_W-1:0]  limb_index_i,
  input  logic [wwva_pkg::LIMB_W-1:0] limb_value_i,
  output wwva_pkg::sts_t              sts_o,
  output logic [wwva_pkg::LIMB_W-1:0] result_limb_o
);

  localparam int W = wwva_pkg::WORD_W;

  logic [W-1:0]   x_q, y_q, m_q;
  logic [W-1:0]   a_q, p_hi_q, p_lo_q;
  logic [2*W-1:0] num_q;
  logic [W-1:0]   rem_q, den_q;
  logic [W-1:0]   res_q, base_q, ebits_q;

  logic [W-1:0]   alu;
  logic [W-1:0]   abs_x, abs_y, quo_neg, rem_neg, low_mask, byte_word;
  logic [W:0]     xy_sum, mul_sum, div_diff;
  logic           x_neg, y_neg, sx_bit;
  logic [wwva_pkg::SHAMT_W-1:0] amt, se_top;
  logic [wwva_pkg::BYTE_W-1:0]  byte_k, byte_pos;
  logic           wr_ok;

  assign x_neg    = x_q[W-1];
  assign y_neg    = y_q[W-1];
  assign abs_x    = x_neg ? (W'(0) - x_q) : x_q;
  assign abs_y    = y_neg ? (W'(0) - y_q) : y_q;
  assign quo_neg  = W'(0) - num_q[W-1:0];
  assign rem_neg  = W'(0) - rem_q;
  assign xy_sum   = {1'b0, x_q} + {1'b0, y_q};
  assign mul_sum  = p_lo_q[0] ? ({1'b0, p_hi_q} + {1'b0, a_q}) : {1'b0, p_hi_q};
  assign div_diff = {rem_q, num_q[2*W-1]} - {1'b0, den_q};

  assign amt      = x_q[wwva_pkg::SHAMT_W-1:0];
  assign byte_k   = x_q[wwva_pkg::BYTE_W-1:0];
  assign byte_pos = wwva_pkg::BYTE_W'(wwva_pkg::BYTES - 1) - byte_k;
  assign byte_word = y_q >> {byte_pos, 3'b000};
  assign se_top   = {byte_k, 3'b111};
  assign low_mask = {W{1'b1}} >> (wwva_pkg::SHAMT_W'(W - 1) - se_top);
  assign sx_bit   = y_q[se_top];

  always_comb begin
    alu = '0;
    case (cmd_i.op)
      wwva_pkg::OP_ADD: alu = xy_sum[W-1:0];
      wwva_pkg::OP_SUB: alu = x_q - y_q;
      wwva_pkg::OP_SIGNEXT: begin
        if (x_q < W'(wwva_pkg::BYTES)) begin
          alu = sx_bit ? (y_q | ~low_mask) : (y_q & low_mask);
        end else begin
          alu = y_q;
        end
      end
      wwva_pkg::OP_LT:     alu = W'(x_q < y_q);
      wwva_pkg::OP_GT:     alu = W'(x_q > y_q);
      wwva_pkg::OP_SLT:    alu = W'($signed(x_q) < $signed(y_q));
      wwva_pkg::OP_EQ:     alu = W'(x_q == y_q);
      wwva_pkg::OP_ISZERO: alu = W'(x_q == '0);
      wwva_pkg::OP_AND:    alu = x_q & y_q;
      wwva_pkg::OP_OR:     alu = x_q | y_q;
      wwva_pkg::OP_XOR:    alu = x_q ^ y_q;
      wwva_pkg::OP_NOT:    alu = ~x_q;
      wwva_pkg::OP_BYTE: begin
        if (x_q < W'(wwva_pkg::BYTES)) begin
          alu = {{(W-8){1'b0}}, byte_word[7:0]};
        end
      end
      wwva_pkg::OP_SHL: begin
        if (x_q < W'(W)) begin
          alu = y_q << amt;
        end
      end
      wwva_pkg::OP_SHR: begin
        if (x_q < W'(W)) begin
          alu = y_q >> amt;
        end
      end
      default: alu = '0;
    endcase
  end

  assign wr_ok = cmd_i.store &&
                 ({{(32-wwva_pkg::IDX_W){1'b0}}, limb_index_i} < 32'(wwva_pkg::WORD_LIMBS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
      m_q <= '0;
    end else if (wr_ok) begin
      case (operand_slot_i)
        wwva_pkg::SLOT_X: x_q[limb_index_i*wwva_pkg::LIMB_W +: wwva_pkg::LIMB_W] <= limb_value_i;
        wwva_pkg::SLOT_Y: y_q[limb_index_i*wwva_pkg::LIMB_W +: wwva_pkg::LIMB_W] <= limb_value_i;
        wwva_pkg::SLOT_M: m_q[limb_index_i*wwva_pkg::LIMB_W +: wwva_pkg::LIMB_W] <= limb_value_i;
        default: ;
      endcase
    end
  end

  // shift-add multiplier: product builds in {p_hi, p_lo}, multiplier bits leave p_lo
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      p_hi_q <= '0;
      case (cmd_i.mul_src)
        wwva_pkg::MUL_XY: begin a_q <= x_q;    p_lo_q <= y_q;    end
        wwva_pkg::MUL_RB: begin a_q <= res_q;  p_lo_q <= base_q; end
        default:          begin a_q <= base_q; p_lo_q <= base_q; end
      endcase
    end else if (cmd_i.mul_step) begin
      p_hi_q <= mul_sum[W:1];
      p_lo_q <= {mul_sum[0], p_lo_q[W-1:1]};
    end
  end

  // restoring divider: numerator is left aligned, quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= '0;
      case (cmd_i.num_src)
        wwva_pkg::NUM_X:   begin num_q <= {x_q, {W{1'b0}}};   den_q <= y_q;   end
        wwva_pkg::NUM_ABS: begin num_q <= {abs_x, {W{1'b0}}}; den_q <= abs_y; end
        wwva_pkg::NUM_SUM: begin num_q <= {xy_sum, {(W-1){1'b0}}}; den_q <= m_q; end
        default:           begin num_q <= {p_hi_q, p_lo_q};   den_q <= m_q;   end
      endcase
    end else if (cmd_i.div_step) begin
      if (!div_diff[W]) begin
        rem_q <= div_diff[W-1:0];
        num_q <= {num_q[2*W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[W-2:0], num_q[2*W-1]};
        num_q <= {num_q[2*W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      case (cmd_i.res_sel)
        wwva_pkg::RES_ALU:  res_q <= alu;
        wwva_pkg::RES_ZERO: res_q <= '0;
        wwva_pkg::RES_ONE:  res_q <= W'(1);
        wwva_pkg::RES_MUL:  res_q <= p_lo_q;
        wwva_pkg::RES_QUO:  res_q <= num_q[W-1:0];
        wwva_pkg::RES_REM:  res_q <= rem_q;
        wwva_pkg::RES_SQUO: res_q <= (x_neg ^ y_neg) ? quo_neg : num_q[W-1:0];
        wwva_pkg::RES_SREM: res_q <= x_neg ? rem_neg : rem_q;
        default:            res_q <= '0;
      endcase
    end
    if (cmd_i.base_from_x) begin
      base_q <= x_q;
    end else if (cmd_i.base_from_mul) begin
      base_q <= p_lo_q;
    end
    if (cmd_i.ebits_load) begin
      ebits_q <= y_q;
    end else if (cmd_i.ebits_shift) begin
      ebits_q <= {1'b0, ebits_q[W-1:1]};
    end
  end

  assign sts_o.y_zero     = (y_q == '0);
  assign sts_o.m_zero     = (m_q == '0);
  assign sts_o.ebits_zero = (ebits_q == '0);
  assign sts_o.ebits_lsb  = ebits_q[0];

  assign result_limb_o = res_q[cmd_i.pos*wwva_pkg::LIMB_W +: wwva_pkg::LIMB_W];

endmodule

/* rtl/wwva_ctrl.sv */
// ----------------------------------------------------------------------------
// wwva_ctrl: controller of the wide-word VM ALU
// Dispatches each executed request, sequences multiplier, divider and
// exponent loops, then streams the result limbs.
// ----------------------------------------------------------------------------
module wwva_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic [wwva_pkg::OP_W-1:0]   opcode_i,
  input  logic                        execute_i,
  input  wwva_pkg::sts_t              sts_i,
  output wwva_pkg::cmd_t              cmd_o,
  output logic                        busy,
  output logic                        result_strobe_o,
  output logic [wwva_pkg::IDX_W-1:0]  result_position_o,
  output logic                        last_limb_o
);

  localparam int W = wwva_pkg::WORD_W;

  wwva_pkg::state_e            state_q, state_d;
  logic [wwva_pkg::OP_W-1:0]   op_q, op_d;
  logic [wwva_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [wwva_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [wwva_pkg::CNT_W-1:0]  div_last;
  logic                        pos_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wwva_pkg::ST_IDLE;
      op_q    <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
    end
  end

  always_comb begin
    case (op_q)
      wwva_pkg::OP_MULMOD: div_last = wwva_pkg::CNT_W'(2 * W - 1);
      wwva_pkg::OP_ADDMOD: div_last = wwva_pkg::CNT_W'(W);
      default:             div_last = wwva_pkg::CNT_W'(W - 1);
    endcase
  end

  assign pos_last = (pos_q == wwva_pkg::POS_W'(wwva_pkg::WORD_LIMBS - 1));

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    cmd_o   = '0;
    cmd_o.op  = op_q;
    cmd_o.pos = pos_q;

    case (state_q)
      wwva_pkg::ST_IDLE: begin
        cmd_o.store = start;
        if (start && execute_i) begin
          op_d    = opcode_i;
          state_d = wwva_pkg::ST_DISPATCH;
        end
      end

      wwva_pkg::ST_DISPATCH: begin
        cnt_d = '0;
        case (op_q)
          wwva_pkg::OP_MUL, wwva_pkg::OP_MULMOD: begin
            if (op_q == wwva_pkg::OP_MULMOD && sts_i.m_zero) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = wwva_pkg::RES_ZERO;
              state_d        = wwva_pkg::ST_EMIT;
            end else begin
              cmd_o.mul_load = 1'b1;
              cmd_o.mul_src  = wwva_pkg::MUL_XY;
              state_d        = wwva_pkg::ST_MUL;
            end
          end
          wwva_pkg::OP_DIV, wwva_pkg::OP_MOD, wwva_pkg::OP_SDIV, wwva_pkg::OP_SMOD: begin
            if (sts_i.y_zero) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = wwva_pkg::RES_ZERO;
              state_d        = wwva_pkg::ST_EMIT;
            end else begin
              cmd_o.div_load = 1'b1;
              cmd_o.num_src  = (op_q == wwva_pkg::OP_SDIV || op_q == wwva_pkg::OP_SMOD) ?
                               wwva_pkg::NUM_ABS : wwva_pkg::NUM_X;
              state_d        = wwva_pkg::ST_DIV;
            end
          end
          wwva_pkg::OP_ADDMOD: begin
            if (sts_i.m_zero) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = wwva_pkg::RES_ZERO;
              state_d        = wwva_pkg::ST_EMIT;
            end else begin
              cmd_o.div_load = 1'b1;
              cmd_o.num_src  = wwva_pkg::NUM_SUM;
              state_d        = wwva_pkg::ST_DIV;
            end
          end
          wwva_pkg::OP_EXP: begin
            cmd_o.res_load    = 1'b1;
            cmd_o.res_sel     = wwva_pkg::RES_ONE;
            cmd_o.base_from_x = 1'b1;
            cmd_o.ebits_load  = 1'b1;
            state_d           = wwva_pkg::ST_EXP_CHK;
          end
          default: begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = wwva_pkg::RES_ALU;
            state_d        = wwva_pkg::ST_EMIT;
          end
        endcase
      end

      wwva_pkg::ST_MUL, wwva_pkg::ST_EXP_RM, wwva_pkg::ST_EXP_SQ: begin
        cmd_o.mul_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == wwva_pkg::CNT_W'(W - 1)) begin
          cnt_d = '0;
          case (state_q)
            wwva_pkg::ST_MUL:    state_d = wwva_pkg::ST_MUL_DONE;
            wwva_pkg::ST_EXP_RM: state_d = wwva_pkg::ST_EXP_RM_DONE;
            default:             state_d = wwva_pkg::ST_EXP_SQ_DONE;
          endcase
        end
      end

      wwva_pkg::ST_MUL_DONE: begin
        if (op_q == wwva_pkg::OP_MULMOD) begin
          cmd_o.div_load = 1'b1;
          cmd_o.num_src  = wwva_pkg::NUM_PROD;
          state_d        = wwva_pkg::ST_DIV;
        end else begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = wwva_pkg::RES_MUL;
          state_d        = wwva_pkg::ST_EMIT;
        end
      end

      wwva_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == div_last) begin
          cnt_d   = '0;
          state_d = wwva_pkg::ST_DIV_DONE;
        end
      end

      wwva_pkg::ST_DIV_DONE: begin
        cmd_o.res_load = 1'b1;
        case (op_q)
          wwva_pkg::OP_DIV:  cmd_o.res_sel = wwva_pkg::RES_QUO;
          wwva_pkg::OP_SDIV: cmd_o.res_sel = wwva_pkg::RES_SQUO;
          wwva_pkg::OP_SMOD: cmd_o.res_sel = wwva_pkg::RES_SREM;
          default:           cmd_o.res_sel = wwva_pkg::RES_REM;
        endcase
        state_d = wwva_pkg::ST_EMIT;
      end

      // square-and-multiply, stops once no exponent bits remain
      wwva_pkg::ST_EXP_CHK: begin
        cnt_d = '0;
        if (sts_i.ebits_zero) begin
          state_d = wwva_pkg::ST_EMIT;
        end else if (sts_i.ebits_lsb) begin
          cmd_o.mul_load = 1'b1;
          cmd_o.mul_src  = wwva_pkg::MUL_RB;
          state_d        = wwva_pkg::ST_EXP_RM;
        end else begin
          cmd_o.mul_load = 1'b1;
          cmd_o.mul_src  = wwva_pkg::MUL_BB;
          state_d        = wwva_pkg::ST_EXP_SQ;
        end
      end

      wwva_pkg::ST_EXP_RM_DONE: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = wwva_pkg::RES_MUL;
        cmd_o.mul_load = 1'b1;
        cmd_o.mul_src  = wwva_pkg::MUL_BB;
        state_d        = wwva_pkg::ST_EXP_SQ;
      end

      wwva_pkg::ST_EXP_SQ_DONE: begin
        cmd_o.base_from_mul = 1'b1;
        cmd_o.ebits_shift   = 1'b1;
        state_d             = wwva_pkg::ST_EXP_CHK;
      end

      wwva_pkg::ST_EMIT: begin
        pos_d = pos_q + 1'b1;
        if (pos_last) begin
          pos_d   = '0;
          state_d = wwva_pkg::ST_IDLE;
        end
      end

      default: state_d = wwva_pkg::ST_IDLE;
    endcase
  end

  assign busy              = (state_q != wwva_pkg::ST_IDLE);
  assign result_strobe_o   = (state_q == wwva_pkg::ST_EMIT);
  assign result_position_o = wwva_pkg::IDX_W'(pos_q);
  assign last_limb_o       = pos_last;

endmodule

/* rtl/wide_word_vm_alu_core.sv */
// ----------------------------------------------------------------------------
// wide_word_vm_alu_core: 256-bit virtual-machine ALU
// Limb loads into operand words x, y, m; an execute request runs the
// opcode and streams four result limbs, least significant first.
// ----------------------------------------------------------------------------
//  channel   | handshake               | payload
//  ----------+-------------------------+--------------------------------------
//  request   | start & !busy           | opcode, operand_slot, limb_index,
//            |                         | limb_value, execute
//  result    | result_strobe_o         | result_limb, result_position, last_limb
//
// A load-only request stores its limb and busy stays low. An execute request
// dispatches, then emits the result limbs for logic, compare and shift ops;
// mul first runs the multiplier (one multiplier bit per cycle), div/mod and
// addmod the divider, mulmod both, exp a multiply per set and a squaring per
// exponent bit up to its highest set bit. Reset clears x, y, m to zero.
// Results cannot be held off: one limb per cycle.
// ----------------------------------------------------------------------------
module wide_word_vm_alu_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [wwva_pkg::OP_W-1:0]   opcode_i,
  input  logic [wwva_pkg::SLOT_W-1:0] operand_slot_i,
  input  logic [wwva_pkg::IDX_W-1:0]  limb_index_i,
  input  logic [wwva_pkg::LIMB_W-1:0] limb_value_i,
  input  logic                        execute_i,
  output logic                        result_strobe_o,
  output logic [wwva_pkg::LIMB_W-1:0] result_limb_o,
  output logic [wwva_pkg::IDX_W-1:0]  result_position_o,
  output logic                        last_limb_o
);

  wwva_pkg::cmd_t cmd;
  wwva_pkg::sts_t sts;

  wwva_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .opcode_i          (opcode_i),
    .execute_i         (execute_i),
    .sts_i             (sts),
    .cmd_o             (cmd),
    .busy              (busy),
    .result_strobe_o   (result_strobe_o),
    .result_position_o (result_position_o),
    .last_limb_o       (last_limb_o)
  );

  wwva_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .operand_slot_i (operand_slot_i),
    .limb_index_i   (limb_index_i),
    .limb_value_i   (limb_value_i),
    .sts_o          (sts),
    .result_limb_o  (result_limb_o)
  );

endmodule
